>>> rtl/core/sapft_pkg.sv
`timescale 1ns / 1ps
package sapft_pkg;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_RD_S  = 2'd1,
    KIND_RD_P  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // control broadcast along one chain of cells
  typedef struct packed {
    logic upd;    // look the key up, bump on hit
    logic allow;  // key may be inserted on a miss
    logic clr;    // empty the chain
  } tbl_ctl_t;

endpackage

>>> rtl/core/sapft_cell.sv
`timescale 1ns / 1ps
module sapft_cell #(
  parameter int KEY_W = 8,
  parameter int CNT_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             upd,
  input  logic             ins,
  input  logic             clr,
  input  logic [KEY_W-1:0] key,
  input  logic             prev_used,
  output logic             used,
  output logic             hit,
  output logic             claim,
  output logic [KEY_W-1:0] key_q,
  output logic [CNT_W-1:0] cnt
);

  assign hit   = used && (key_q == key);
  // first empty cell in the chain takes a new key
  assign claim = ins && prev_used && !used;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      used <= 1'b0;
    end else if (claim) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && hit) begin
      if (cnt != '1) cnt <= cnt + CNT_W'(1);
    end else if (claim) begin
      key_q <= key;
      cnt   <= CNT_W'(1);
    end
  end

endmodule

>>> rtl/core/sapft_chain.sv
`timescale 1ns / 1ps
module sapft_chain #(
  parameter int ENTRIES = 64,
  parameter int KEY_W   = 8,
  parameter int CNT_W   = 16,
  localparam int FW     = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  sapft_pkg::tbl_ctl_t ctl,
  input  logic [KEY_W-1:0]    key,
  input  logic [5:0]          rd_index,
  output logic [FW-1:0]       fill_next,
  output logic                lost,
  output logic                rd_valid,
  output logic [KEY_W-1:0]    rd_key,
  output logic [CNT_W-1:0]    rd_cnt
);

  logic [FW-1:0]    fill;
  logic [ENTRIES:0] used_link;
  logic [ENTRIES-1:0] hit_v, claim_v, sel_v;
  logic [KEY_W-1:0] key_v [ENTRIES];
  logic [CNT_W-1:0] cnt_v [ENTRIES];
  logic any_hit, full, ins;

  assign used_link[0] = 1'b1;
  assign any_hit = |hit_v;
  assign full    = (fill == FW'(ENTRIES));
  assign ins     = ctl.upd && ctl.allow && !any_hit;
  assign lost    = ins && full;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign sel_v[i] = (32'(rd_index) == i);
    sapft_cell #(.KEY_W(KEY_W), .CNT_W(CNT_W)) u_cell (
      .clk(clk), .rst(rst), .upd(ctl.upd), .ins(ins), .clr(ctl.clr),
      .key(key), .prev_used(used_link[i]), .used(used_link[i+1]),
      .hit(hit_v[i]), .claim(claim_v[i]), .key_q(key_v[i]), .cnt(cnt_v[i])
    );
  end

  always_comb begin
    rd_valid = 1'b0;
    rd_key   = '0;
    rd_cnt   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel_v[i] && used_link[i+1]) begin
        rd_valid = 1'b1;
        rd_key   = rd_key | key_v[i];
        rd_cnt   = rd_cnt | cnt_v[i];
      end
    end
  end

  always_comb begin
    if (ctl.clr) fill_next = '0;
    else if (|claim_v) fill_next = fill + FW'(1);
    else fill_next = fill;
  end

  always_ff @(posedge clk) begin
    if (rst) fill <= '0;
    else fill <= fill_next;
  end

endmodule

>>> rtl/core/symbol_and_pair_frequency_table.sv
`timescale 1ns / 1ps
// An accepted item is registered and raises busy; the result strobe (done) is registered from busy.
// A new item is not taken while busy is high; busy is high for the cycle in which the
// chains of cells compare the key against every entry and update in place.
// Reset (rst, synchronous) empties both tables and clears the pair history and lost flag.
// Results cannot be stalled: done is high for one cycle per item.
module symbol_and_pair_frequency_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int COUNT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  ch,
  input  logic [5:0]  index,
  output logic        done,
  output logic [6:0]  distinct_singles,
  output logic [6:0]  distinct_pairs,
  output logic [7:0]  entry_first,
  output logic [7:0]  entry_second,
  output logic [15:0] entry_count,
  output logic        entry_valid,
  output logic        entry_repeated,
  output logic        lost_insert
);

  localparam int FW = $clog2(TABLE_ENTRIES + 1);

  logic [1:0] op_kind;
  logic [7:0] op_ch;
  logic [5:0] op_index;
  logic [7:0] prev_char;
  logic       prev_valid;
  logic       overflow;

  sapft_pkg::tbl_ctl_t s_ctl, p_ctl;
  logic [FW-1:0] s_fill, p_fill;
  logic s_lost, p_lost, s_rv, p_rv;
  logic [7:0]  s_key;
  logic [15:0] p_key;
  logic [COUNT_BITS-1:0] s_cnt, p_cnt, r_cnt;
  logic is_text, is_clr, overflow_next;

  assign is_text = busy && (op_kind == sapft_pkg::KIND_TEXT);
  assign is_clr  = busy && (op_kind == sapft_pkg::KIND_CLEAR);

  always_comb begin
    s_ctl.upd   = is_text;
    s_ctl.allow = (op_ch != sapft_pkg::SPACE_CHAR);
    s_ctl.clr   = is_clr;
    p_ctl.upd   = is_text && prev_valid;
    p_ctl.allow = (op_ch != sapft_pkg::SPACE_CHAR) && (prev_char != sapft_pkg::SPACE_CHAR);
    p_ctl.clr   = is_clr;
  end

  sapft_chain #(.ENTRIES(TABLE_ENTRIES), .KEY_W(8), .CNT_W(COUNT_BITS)) u_singles (
    .clk(clk), .rst(rst), .ctl(s_ctl), .key(op_ch), .rd_index(op_index),
    .fill_next(s_fill), .lost(s_lost), .rd_valid(s_rv), .rd_key(s_key), .rd_cnt(s_cnt)
  );

  sapft_chain #(.ENTRIES(TABLE_ENTRIES), .KEY_W(16), .CNT_W(COUNT_BITS)) u_pairs (
    .clk(clk), .rst(rst), .ctl(p_ctl), .key({prev_char, op_ch}), .rd_index(op_index),
    .fill_next(p_fill), .lost(p_lost), .rd_valid(p_rv), .rd_key(p_key), .rd_cnt(p_cnt)
  );

  assign overflow_next = is_clr ? 1'b0 : (overflow || s_lost || p_lost);
  assign r_cnt = (op_kind == sapft_pkg::KIND_RD_S) ? s_cnt : p_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      prev_valid <= 1'b0;
      prev_char  <= '0;
      overflow   <= 1'b0;
    end else begin
      done <= busy;
      if (busy) begin
        busy     <= 1'b0;
        overflow <= overflow_next;
        if (is_text) begin
          prev_char  <= op_ch;
          prev_valid <= 1'b1;
        end else if (is_clr) begin
          prev_char  <= '0;
          prev_valid <= 1'b0;
        end
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  // hold the item while the cells work on it
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_kind  <= kind;
      op_ch    <= ch;
      op_index <= index;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      distinct_singles <= 7'(s_fill);
      distinct_pairs   <= 7'(p_fill);
      lost_insert      <= overflow_next;
      if (op_kind == sapft_pkg::KIND_RD_S && s_rv) begin
        entry_first    <= s_key;
        entry_second   <= '0;
        entry_count    <= 16'(r_cnt);
        entry_valid    <= 1'b1;
        entry_repeated <= (r_cnt > COUNT_BITS'(1));
      end else if (op_kind == sapft_pkg::KIND_RD_P && p_rv) begin
        entry_first    <= p_key[15:8];
        entry_second   <= p_key[7:0];
        entry_count    <= 16'(r_cnt);
        entry_valid    <= 1'b1;
        entry_repeated <= (r_cnt > COUNT_BITS'(1));
      end else begin
        entry_first    <= '0;
        entry_second   <= '0;
        entry_count    <= '0;
        entry_valid    <= 1'b0;
        entry_repeated <= 1'b0;
      end
    end
  end

endmodule

>>> verif/tb_symbol_and_pair_frequency_table.sv
`timescale 1ns / 1ps
module tb_symbol_and_pair_frequency_table;

  localparam int ENTRIES   = 64;
  localparam int COUNT_TOP = 65535;
  localparam int LIMIT     = 100000;

  typedef struct {
    sapft_pkg::kind_t k;
    logic [7:0]       c;
    logic [5:0]       i;
  } text_item_t;

  typedef struct {
    logic [6:0]  singles;
    logic [6:0]  pairs;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [15:0] count;
    logic        valid;
    logic        repeated;
    logic        lost;
  } freq_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = sapft_pkg::KIND_TEXT;
  logic [7:0]  ch = '0;
  logic [5:0]  index = '0;
  logic        done;
  logic [6:0]  distinct_singles;
  logic [6:0]  distinct_pairs;
  logic [7:0]  entry_first;
  logic [7:0]  entry_second;
  logic [15:0] entry_count;
  logic        entry_valid;
  logic        entry_repeated;
  logic        lost_insert;

  symbol_and_pair_frequency_table u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .ch(ch), .index(index), .done(done),
    .distinct_singles(distinct_singles), .distinct_pairs(distinct_pairs),
    .entry_first(entry_first), .entry_second(entry_second),
    .entry_count(entry_count), .entry_valid(entry_valid),
    .entry_repeated(entry_repeated), .lost_insert(lost_insert)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_item_t   pending_items[$];
  freq_result_t expected_results[$];
  int           errors = 0;
  int           cycles = 0;
  int           gap_left = 0;
  bit           no_idle = 1'b0;

  // shadow tables
  logic [7:0]  sh_single_ch[ENTRIES];
  int          sh_single_cnt[ENTRIES];
  logic [15:0] sh_pair_key[ENTRIES];
  int          sh_pair_cnt[ENTRIES];
  int          sh_single_fill = 0;
  int          sh_pair_fill = 0;
  logic [7:0]  sh_prev = '0;
  bit          sh_prev_valid = 1'b0;
  bit          sh_lost = 1'b0;

  function automatic int saturate_inc(int c);
    return (c >= COUNT_TOP) ? COUNT_TOP : c + 1;
  endfunction

  function automatic freq_result_t count_text(sapft_pkg::kind_t k, logic [7:0] c,
                                              logic [5:0] i);
    freq_result_t r;
    bit hit;
    logic [15:0] key;
    r = '{default: '0};
    case (k)
      sapft_pkg::KIND_TEXT: begin
        hit = 1'b0;
        for (int n = 0; n < sh_single_fill; n++)
          if (!hit && sh_single_ch[n] == c) begin
            sh_single_cnt[n] = saturate_inc(sh_single_cnt[n]);
            hit = 1'b1;
          end
        if (!hit && c != sapft_pkg::SPACE_CHAR) begin
          if (sh_single_fill >= ENTRIES) sh_lost = 1'b1;
          else begin
            sh_single_ch[sh_single_fill] = c;
            sh_single_cnt[sh_single_fill] = 1;
            sh_single_fill++;
          end
        end
        if (sh_prev_valid) begin
          key = {sh_prev, c};
          hit = 1'b0;
          for (int n = 0; n < sh_pair_fill; n++)
            if (!hit && sh_pair_key[n] == key) begin
              sh_pair_cnt[n] = saturate_inc(sh_pair_cnt[n]);
              hit = 1'b1;
            end
          if (!hit && sh_prev != sapft_pkg::SPACE_CHAR && c != sapft_pkg::SPACE_CHAR) begin
            if (sh_pair_fill >= ENTRIES) sh_lost = 1'b1;
            else begin
              sh_pair_key[sh_pair_fill] = key;
              sh_pair_cnt[sh_pair_fill] = 1;
              sh_pair_fill++;
            end
          end
        end
        sh_prev = c;
        sh_prev_valid = 1'b1;
      end
      sapft_pkg::KIND_RD_S: begin
        if (i < sh_single_fill) begin
          r.valid = 1'b1;
          r.first = sh_single_ch[i];
          r.count = sh_single_cnt[i][15:0];
          r.repeated = sh_single_cnt[i] > 1;
        end
      end
      sapft_pkg::KIND_RD_P: begin
        if (i < sh_pair_fill) begin
          r.valid = 1'b1;
          r.first = sh_pair_key[i][15:8];
          r.second = sh_pair_key[i][7:0];
          r.count = sh_pair_cnt[i][15:0];
          r.repeated = sh_pair_cnt[i] > 1;
        end
      end
      default: begin
        sh_single_fill = 0;
        sh_pair_fill = 0;
        sh_prev = '0;
        sh_prev_valid = 1'b0;
        sh_lost = 1'b0;
      end
    endcase
    r.singles = sh_single_fill[6:0];
    r.pairs = sh_pair_fill[6:0];
    r.lost = sh_lost;
    return r;
  endfunction

  // driver: predict on acceptance, then hold, idle or advance
  always @(posedge clk) begin
    text_item_t nxt;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy)
        expected_results.push_back(count_text(sapft_pkg::kind_t'(kind), ch, index));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          kind <= nxt.k;
          ch <= nxt.c;
          index <= nxt.i;
          start <= 1'b1;
          gap_left <= no_idle ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 199) == 0) no_idle <= !no_idle;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    freq_result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, singles %0d pairs %0d",
                 $time, distinct_singles, distinct_pairs);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (distinct_singles !== e.singles) begin
          $display("%0t: distinct_singles exp %0d got %0d", $time, e.singles, distinct_singles);
          errors++;
        end
        if (distinct_pairs !== e.pairs) begin
          $display("%0t: distinct_pairs exp %0d got %0d", $time, e.pairs, distinct_pairs);
          errors++;
        end
        if (entry_first !== e.first) begin
          $display("%0t: entry_first exp %h got %h", $time, e.first, entry_first);
          errors++;
        end
        if (entry_second !== e.second) begin
          $display("%0t: entry_second exp %h got %h", $time, e.second, entry_second);
          errors++;
        end
        if (entry_count !== e.count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, e.count, entry_count);
          errors++;
        end
        if (entry_valid !== e.valid) begin
          $display("%0t: entry_valid exp %b got %b", $time, e.valid, entry_valid);
          errors++;
        end
        if (entry_repeated !== e.repeated) begin
          $display("%0t: entry_repeated exp %b got %b", $time, e.repeated, entry_repeated);
          errors++;
        end
        if (lost_insert !== e.lost) begin
          $display("%0t: lost_insert exp %b got %b", $time, e.lost, lost_insert);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_item(sapft_pkg::kind_t k, logic [7:0] c, logic [5:0] i);
    pending_items.push_back('{k: k, c: c, i: i});
  endtask

  task automatic add_reads(int n);
    for (int r = 0; r < n; r++)
      add_item($urandom_range(0, 1) ? sapft_pkg::KIND_RD_S : sapft_pkg::KIND_RD_P,
               8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
  endtask

  initial begin
    int made;
    int len;
    logic [7:0] alpha[5];
    // directed: empty reads, short string with spaces, extremes
    add_item(sapft_pkg::KIND_RD_S, 8'hff, 6'd0);
    add_item(sapft_pkg::KIND_RD_P, 8'h00, 6'd63);
    add_item(sapft_pkg::KIND_TEXT, 8'h61, 6'd63);
    add_item(sapft_pkg::KIND_TEXT, sapft_pkg::SPACE_CHAR, 6'd0);
    add_item(sapft_pkg::KIND_TEXT, 8'h61, 6'd0);
    add_item(sapft_pkg::KIND_TEXT, 8'h62, 6'd0);
    add_item(sapft_pkg::KIND_TEXT, 8'h61, 6'd0);
    add_item(sapft_pkg::KIND_TEXT, 8'h62, 6'd0);
    add_item(sapft_pkg::KIND_TEXT, 8'h00, 6'd0);
    add_item(sapft_pkg::KIND_TEXT, 8'hff, 6'd0);
    add_item(sapft_pkg::KIND_TEXT, sapft_pkg::SPACE_CHAR, 6'd0);
    add_item(sapft_pkg::KIND_TEXT, sapft_pkg::SPACE_CHAR, 6'd0);
    for (int n = 0; n < 5; n++) add_item(sapft_pkg::KIND_RD_S, 8'h00, n[5:0]);
    for (int n = 0; n < 5; n++) add_item(sapft_pkg::KIND_RD_P, 8'hff, n[5:0]);
    add_item(sapft_pkg::KIND_RD_S, 8'h00, 6'd63);
    add_item(sapft_pkg::KIND_CLEAR, 8'hff, 6'd63);
    add_item(sapft_pkg::KIND_RD_S, 8'h00, 6'd0);

    // repeat one byte to build up a single and a pair count
    add_item(sapft_pkg::KIND_CLEAR, 8'h00, 6'd0);
    for (int n = 0; n < 40; n++) add_item(sapft_pkg::KIND_TEXT, 8'h61, 6'd0);
    add_item(sapft_pkg::KIND_RD_S, 8'h00, 6'd0);
    add_item(sapft_pkg::KIND_RD_P, 8'h00, 6'd0);

    // fill both tables past their size
    add_item(sapft_pkg::KIND_CLEAR, 8'h00, 6'd0);
    for (int n = 0; n < 80; n++) add_item(sapft_pkg::KIND_TEXT, 8'h40 + n[7:0], 6'd0);
    add_item(sapft_pkg::KIND_TEXT, 8'h41, 6'd0);
    add_item(sapft_pkg::KIND_RD_S, 8'h00, 6'd63);
    add_item(sapft_pkg::KIND_RD_P, 8'h00, 6'd63);
    add_item(sapft_pkg::KIND_RD_S, 8'h00, 6'd1);

    // random: mostly strings then reads, some noise
    made = 0;
    while (made < 1400) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 2) == 0)
          add_item(sapft_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)), '0);
        for (int a = 0; a < 4; a++) alpha[a] = 8'($urandom_range(0, 255));
        alpha[4] = sapft_pkg::SPACE_CHAR;
        len = $urandom_range(3, 40);
        for (int n = 0; n < len; n++)
          add_item(sapft_pkg::KIND_TEXT,
                   $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                             : alpha[$urandom_range(0, 4)],
                   6'($urandom_range(0, 63)));
        add_reads($urandom_range(2, 10));
        made += len + 11;
      end else begin
        for (int n = 0; n < 10; n++)
          add_item(sapft_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   6'($urandom_range(0, 63)));
        made += 10;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sapft_pkg.sv
rtl/core/sapft_cell.sv
rtl/core/sapft_chain.sv
rtl/core/symbol_and_pair_frequency_table.sv
verif/tb_symbol_and_pair_frequency_table.sv
